// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define SBSI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check a property on every clock edge, reset included
`define SBSI_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- rtl/sbsi_pkg.sv -----
`timescale 1ns / 1ps
package sbsi_pkg;

   localparam int NumW   = 34;
   localparam int QDepth = 4;
   localparam int QAddrW = $clog2(QDepth);
   localparam int QCntW  = QAddrW + 1;

   typedef struct packed {
      logic            zero;
      logic            ok;
      logic [NumW-1:0] a;
      logic [NumW-1:0] b;
      logic [NumW-1:0] q;
   } slab_type;

   typedef slab_type [2:0] item_type;

   typedef logic [2:0][31:0] coord_type;
   typedef logic [2:0][30:0] size_type;

endpackage

// ----- rtl/sbsi_front.sv -----
`timescale 1ns / 1ps
module sbsi_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  sbsi_pkg::coord_type start,
   input  sbsi_pkg::coord_type stop,
   input  sbsi_pkg::coord_type center,
   input  sbsi_pkg::size_type  size,
   output logic               deq_valid,
   output sbsi_pkg::item_type deq_item,
   input  logic               deq
);

   sbsi_pkg::item_type slab_in;
   sbsi_pkg::item_type f_item_ff;
   logic               f_v_ff;
   sbsi_pkg::item_type mem_ff [sbsi_pkg::QDepth];
   logic [sbsi_pkg::QAddrW-1:0] wp_ff, rp_ff;
   logic [sbsi_pkg::QCntW-1:0]  cnt_ff, cnt_in;
   logic enq, q_full, f_ready;

   always_comb begin
      logic signed [35:0] p2, e2, c2, s36, bmin, bmax, dir, a, b, q, ac, bc;
      for (int i = 0; i < 3; i++) begin
         p2   = {{3{start[i][31]}}, start[i], 1'b0};
         e2   = {{3{stop[i][31]}}, stop[i], 1'b0};
         c2   = {{3{center[i][31]}}, center[i], 1'b0};
         s36  = {5'b0, size[i]};
         bmin = c2 - s36;
         bmax = c2 + s36;
         dir  = e2 - p2;
         if (dir > 0) begin
            a = bmin - p2;
            b = bmax - p2;
            q = dir;
         end else begin
            a = p2 - bmax;
            b = p2 - bmin;
            q = -dir;
         end
         ac = (a > 0) ? a : 36'sd0;
         bc = (b < q) ? b : q;
         slab_in[i].zero = (dir == 0);
         slab_in[i].ok   = (dir == 0) ? !(p2 < bmin || p2 > bmax) : !(a > q || b < 0);
         slab_in[i].a    = ac[sbsi_pkg::NumW-1:0];
         slab_in[i].b    = bc[sbsi_pkg::NumW-1:0];
         slab_in[i].q    = q[sbsi_pkg::NumW-1:0];
      end
   end

   assign q_full    = (cnt_ff == sbsi_pkg::QCntW'(sbsi_pkg::QDepth));
   assign enq       = f_v_ff && !q_full;
   assign f_ready   = !f_v_ff || enq;
   assign full      = !f_ready;
   assign deq_valid = (cnt_ff != '0);
   assign deq_item  = mem_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (enq && !deq) cnt_in = cnt_ff + 1'b1;
      if (!enq && deq) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push && f_ready) f_v_ff <= 1'b1;
         else if (enq) f_v_ff <= 1'b0;
         if (enq) wp_ff <= wp_ff + 1'b1;
         if (deq) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && f_ready) f_item_ff <= slab_in;
      if (enq) mem_ff[wp_ff] <= f_item_ff;
   end

endmodule

// ----- rtl/sbsi_back.sv -----
`timescale 1ns / 1ps
module sbsi_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               deq_valid,
   input  sbsi_pkg::item_type deq_item,
   output logic               deq,
   output logic               empty,
   input  logic               pop,
   output logic               hit
);

   localparam int PW = 2 * sbsi_pkg::NumW;

   logic                 v1_ff;
   logic [2:0]           zero_ff, ok_ff;
   logic [2:0][2:0][PW-1:0] lhs_ff, rhs_ff;
   logic                 hit_res;
   logic                 mem_ff [sbsi_pkg::QDepth];
   logic [sbsi_pkg::QAddrW-1:0] wp_ff, rp_ff;
   logic [sbsi_pkg::QCntW-1:0]  cnt_ff, cnt_in;
   logic [sbsi_pkg::QCntW:0]    used;
   logic opop;

   assign used  = {1'b0, cnt_ff} + {{sbsi_pkg::QCntW{1'b0}}, v1_ff};
   assign deq   = deq_valid && (used < (sbsi_pkg::QCntW + 1)'(sbsi_pkg::QDepth));
   assign empty = (cnt_ff == '0);
   assign opop  = pop && !empty;
   assign hit   = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         zero_ff[i] <= deq_item[i].zero;
         ok_ff[i]   <= deq_item[i].ok;
         for (int j = 0; j < 3; j++) begin
            if (i != j) begin
               lhs_ff[i][j] <= PW'(deq_item[i].a) * PW'(deq_item[j].q);
               rhs_ff[i][j] <= PW'(deq_item[j].b) * PW'(deq_item[i].q);
            end else begin
               lhs_ff[i][j] <= '0;
               rhs_ff[i][j] <= '0;
            end
         end
      end
   end

   always_comb begin
      hit_res = &ok_ff;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            if (!zero_ff[i] && !zero_ff[j] && lhs_ff[i][j] > rhs_ff[i][j]) hit_res = 1'b0;
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (v1_ff && !opop) cnt_in = cnt_ff + 1'b1;
      if (!v1_ff && opop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         v1_ff <= deq;
         if (v1_ff) wp_ff <= wp_ff + 1'b1;
         if (opop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (v1_ff) mem_ff[wp_ff] <= hit_res;
   end

endmodule

// ----- rtl/segment_box_slab_intersect.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Segment versus box hit test. Takes one item per cycle while full is low;
// an accepted item passes the input stage, slab queue, product stage and
// result queue in turn. Each axis yields an exact rational slab interval;
// the back end compares all axis pairs by cross products in one registered
// stage of 34 x 34 bit multipliers, so throughput stays one item per cycle
// while pop keeps up. Results come out in order.
module segment_box_slab_intersect (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_start_z,
   input  logic signed [31:0] req_end_x,
   input  logic signed [31:0] req_end_y,
   input  logic signed [31:0] req_end_z,
   input  logic signed [31:0] req_box_center_x,
   input  logic signed [31:0] req_box_center_y,
   input  logic signed [31:0] req_box_center_z,
   input  logic [30:0]        req_box_size_x,
   input  logic [30:0]        req_box_size_y,
   input  logic [30:0]        req_box_size_z,
   output logic               empty,
   input  logic               pop,
   output logic               rsp_hit
);

   sbsi_pkg::coord_type start, stop, center;
   sbsi_pkg::size_type  size;
   sbsi_pkg::item_type  deq_item;
   logic deq_valid, deq;

   assign start  = {req_start_z, req_start_y, req_start_x};
   assign stop   = {req_end_z, req_end_y, req_end_x};
   assign center = {req_box_center_z, req_box_center_y, req_box_center_x};
   assign size   = {req_box_size_z, req_box_size_y, req_box_size_x};

   sbsi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .start     (start),
      .stop      (stop),
      .center    (center),
      .size      (size),
      .deq_valid (deq_valid),
      .deq_item  (deq_item),
      .deq       (deq)
   );

   sbsi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .deq_valid (deq_valid),
      .deq_item  (deq_item),
      .deq       (deq),
      .empty     (empty),
      .pop       (pop),
      .hit       (rsp_hit)
   );

   `SBSI_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> (empty && !full), "not idle after reset")
   `SBSI_ASSERT(a_full_backed_up, full |-> !empty, "full while no result waits")
   `SBSI_ASSERT(a_deq_has_item, deq |-> deq_valid, "slab queue read while empty")

endmodule
